// ===== hdl/fce_pkg.sv =====
// fce_pkg: shared constants, types and helpers for the fillet curve evaluator
// used by the interfaces, the divider and square-root cells and the top level
`default_nettype none

package fce_pkg;

   localparam int FRAC_BITS = 16;
   localparam int XW        = 32;                  // coordinate width
   localparam int RW        = 31;                  // radius width
   localparam int DIV_STEPS = XW + FRAC_BITS;      // quotient bits of the slope
   localparam int SQ_STEPS  = RW;                  // root bits
   localparam int RAD_W     = 2 * RW;              // radicand width
   localparam int SQ_REM_W  = RW + 2;
   localparam int QL        = DIV_STEPS / 2;       // low part of the slope product
   localparam int QH        = DIV_STEPS - QL;
   localparam int PW        = XW + DIV_STEPS;      // full product width
   localparam int MAG_W     = PW - FRAC_BITS;
   localparam int SUM_W     = MAG_W + 2;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEG_X0   = 3'd0,
      CSR_SEG_Y0   = 3'd1,
      CSR_SEG_X1   = 3'd2,
      CSR_SEG_Y1   = 3'd3,
      CSR_CENTER_X = 3'd4,
      CSR_CENTER_Y = 3'd5,
      CSR_RADIUS   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic          on_seg;
      logic          dom_err;
      logic [XW-1:0] dx;
      logic [RW-1:0] root;
   } fce_side_type;

   // clamp a wide signed value into the coordinate range
   function automatic logic signed [XW-1:0] sat_y(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = (SUM_W'(1) <<< (XW - 1)) - SUM_W'(1);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         sat_y = hi[XW-1:0];
      end else if (v < lo) begin
         sat_y = lo[XW-1:0];
      end else begin
         sat_y = v[XW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/fce_if.sv =====
// fce_req_if / fce_rsp_if: valid-ready channels of the fillet curve evaluator
// depends on fce_pkg for field widths
`default_nettype none

interface fce_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [fce_pkg::XW-1:0]  x_coord;
   modport source (output valid, output x_coord, input ready);
   modport sink   (input valid, input x_coord, output ready);
endinterface

interface fce_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [fce_pkg::XW-1:0]  y_coord;
   logic                           on_segment;
   logic                           domain_error;
   modport source (output valid, output y_coord, output on_segment, output domain_error,
                   input ready);
   modport sink   (input valid, input y_coord, input on_segment, input domain_error,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/fce_div_cell.sv =====
// fce_div_cell: one restoring division step of the slope divider chain
// depends on fce_pkg
`default_nettype none

module fce_div_cell (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [fce_pkg::XW-1:0]         dw,
   input  wire logic                           nbit,
   input  wire logic [fce_pkg::XW-1:0]         rem_i,
   input  wire logic [fce_pkg::DIV_STEPS-1:0]  q_i,
   output      logic [fce_pkg::XW-1:0]         rem_o,
   output      logic [fce_pkg::DIV_STEPS-1:0]  q_o
);

   logic [fce_pkg::XW:0]          rem2;
   logic [fce_pkg::XW:0]          diff;
   logic [fce_pkg::XW-1:0]        rem_in;
   logic [fce_pkg::DIV_STEPS-1:0] q_in;
   logic [fce_pkg::XW-1:0]        rem_ff;
   logic [fce_pkg::DIV_STEPS-1:0] q_ff;

   always_comb begin
      rem2 = {rem_i, nbit};
      diff = rem2 - {1'b0, dw};
      if (rem2 >= {1'b0, dw}) begin
         rem_in = diff[fce_pkg::XW-1:0];
         q_in   = {q_i[fce_pkg::DIV_STEPS-2:0], 1'b1};
      end else begin
         rem_in = rem2[fce_pkg::XW-1:0];
         q_in   = {q_i[fce_pkg::DIV_STEPS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign rem_o = rem_ff;
   assign q_o   = q_ff;

endmodule

`default_nettype wire

// ===== hdl/fce_sqrt_cell.sv =====
// fce_sqrt_cell: one digit step of the floored square-root chain
// depends on fce_pkg
`default_nettype none

module fce_sqrt_cell (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [fce_pkg::RAD_W-1:0]     rad_i,
   input  wire logic [fce_pkg::SQ_REM_W-1:0]  rem_i,
   input  wire logic [fce_pkg::RW-1:0]        root_i,
   output      logic [fce_pkg::RAD_W-1:0]     rad_o,
   output      logic [fce_pkg::SQ_REM_W-1:0]  rem_o,
   output      logic [fce_pkg::RW-1:0]        root_o
);

   logic [fce_pkg::SQ_REM_W+1:0] rem2;
   logic [fce_pkg::SQ_REM_W+1:0] trial;
   logic [fce_pkg::SQ_REM_W+1:0] diff;
   logic [fce_pkg::SQ_REM_W-1:0] rem_in;
   logic [fce_pkg::RW-1:0]       root_in;
   logic [fce_pkg::RAD_W-1:0]    rad_ff;
   logic [fce_pkg::SQ_REM_W-1:0] rem_ff;
   logic [fce_pkg::RW-1:0]       root_ff;

   always_comb begin
      rem2  = {rem_i, rad_i[fce_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, root_i, 2'b01};
      diff  = rem2 - trial;
      if (rem2 >= trial) begin
         rem_in  = diff[fce_pkg::SQ_REM_W-1:0];
         root_in = {root_i[fce_pkg::RW-2:0], 1'b1};
      end else begin
         rem_in  = rem2[fce_pkg::SQ_REM_W-1:0];
         root_in = {root_i[fce_pkg::RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= {rad_i[fce_pkg::RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

`default_nettype wire

// ===== hdl/fillet_curve_evaluator_core.sv =====
// fillet_curve_evaluator_core: top level, front end, cell chains and result stages
// depends on fce_pkg, fce_if, fce_div_cell and fce_sqrt_cell
`default_nettype none

// usage
// - req_ch carries one x_coord per item, rsp_ch one y_coord, on_segment and
//   domain_error per item, in the same order; both are valid/ready channels
// - csr_we/csr_index/csr_wdata write the segment ends, circle center and
//   radius; write only while no item is in flight
// - one item per cycle sustained while rsp is not stalled; items pass
//   alongside the slope divider chain of 32 + FRAC_BITS cells, one
//   quotient bit per cell
// - the square root runs in a parallel chain of 31 cells, two radicand bits
//   per cell, and finishes before the divider
// - the whole pipeline moves as one; it holds when rsp is valid and not
//   taken, and req_ready is low only in that case
// - a stalled result stays in the output register with its payload fixed
// - reset clears the configuration registers and all stage valid bits;
//   no results are pending afterwards and the block takes an item in the next cycle
// - segment width zero or negative radicand: y_coord is 0, domain_error set
module fillet_curve_evaluator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   fce_req_if.sink                              req_ch,
   fce_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [fce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fce_pkg::XW-1:0]          csr_wdata
);

   localparam int XW   = fce_pkg::XW;
   localparam int RW   = fce_pkg::RW;
   localparam int DS   = fce_pkg::DIV_STEPS;
   localparam int SQ   = fce_pkg::SQ_STEPS;
   localparam int FB   = fce_pkg::FRAC_BITS;

   // configuration registers
   logic signed [XW-1:0] seg_x0_ff, seg_y0_ff, seg_x1_ff, seg_y1_ff;
   logic signed [XW-1:0] center_x_ff, center_y_ff;
   logic [RW-1:0]        radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_x0_ff   <= '0;
         seg_y0_ff   <= '0;
         seg_x1_ff   <= '0;
         seg_y1_ff   <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_we) begin
         unique case (fce_pkg::csr_idx_type'(csr_index))
            fce_pkg::CSR_SEG_X0:   seg_x0_ff   <= csr_wdata;
            fce_pkg::CSR_SEG_Y0:   seg_y0_ff   <= csr_wdata;
            fce_pkg::CSR_SEG_X1:   seg_x1_ff   <= csr_wdata;
            fce_pkg::CSR_SEG_Y1:   seg_y1_ff   <= csr_wdata;
            fce_pkg::CSR_CENTER_X: center_x_ff <= csr_wdata;
            fce_pkg::CSR_CENTER_Y: center_y_ff <= csr_wdata;
            fce_pkg::CSR_RADIUS:   radius_ff   <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   // derived constants, refreshed every cycle from the registers
   logic signed [XW:0]  dy_full;
   logic [XW:0]         dy_abs;
   logic [XW:0]         dw_full;
   logic [DS-1:0]       num_ff;       // |dy| << FRAC_BITS
   logic [XW-1:0]       dw_ff;
   logic                dy_neg_ff;
   logic [2*RW-1:0]     r2_ff;

   always_comb begin
      dy_full = (XW+1)'(seg_y1_ff) - (XW+1)'(seg_y0_ff);
      dy_abs  = dy_full[XW] ? (XW+1)'(-dy_full) : (XW+1)'(dy_full);
      dw_full = (XW+1)'(seg_x1_ff) - (XW+1)'(seg_x0_ff);
   end

   always_ff @(posedge clock) begin
      num_ff    <= {dy_abs[XW-1:0], {FB{1'b0}}};
      dw_ff     <= dw_full[XW-1:0];
      dy_neg_ff <= dy_full[XW];
      r2_ff     <= (2*RW)'(radius_ff) * (2*RW)'(radius_ff);
   end

   // global advance: everything moves unless a result waits unread
   logic rsp_v_ff;
   logic adv;

   assign adv          = !rsp_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // input register
   logic                x_v_ff;
   logic signed [XW-1:0] x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_v_ff <= 1'b0;
      end else if (adv) begin
         x_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= req_ch.x_coord;
      end
   end

   // stage a: region decision and offsets
   logic signed [XW:0]    dx_full;
   logic signed [XW:0]    d_full;
   logic [XW:0]           ad_full;
   logic                  on_seg_a;
   fce_pkg::fce_side_type a_side_in;
   fce_pkg::fce_side_type a_side_ff;
   logic [XW-1:0]         a_ad_ff;
   logic                  a_v_ff;

   always_comb begin
      on_seg_a  = (x_ff >= seg_x0_ff) && (x_ff <= seg_x1_ff);
      dx_full   = (XW+1)'(x_ff) - (XW+1)'(seg_x0_ff);
      d_full    = (XW+1)'(x_ff) - (XW+1)'(center_x_ff);
      ad_full   = d_full[XW] ? (XW+1)'(-d_full) : (XW+1)'(d_full);
      a_side_in.on_seg  = on_seg_a;
      a_side_in.dom_err = on_seg_a && (seg_x0_ff == seg_x1_ff);
      a_side_in.dx      = dx_full[XW-1:0];
      a_side_in.root    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= x_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= a_side_in;
         a_ad_ff   <= ad_full[XW-1:0];
      end
   end

   // stage b: square of the center offset
   fce_pkg::fce_side_type b_side_ff;
   logic [2*XW-1:0]       b_d2_ff;
   logic                  b_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_side_ff <= a_side_ff;
         b_d2_ff   <= (2*XW)'(a_ad_ff) * (2*XW)'(a_ad_ff);
      end
   end

   // stage c: radicand and its sign check
   fce_pkg::fce_side_type c_side_in;
   fce_pkg::fce_side_type c_side_ff;
   logic [2*XW-1:0]       r2_wide;
   logic [2*XW-1:0]       rad_wide;
   logic [fce_pkg::RAD_W-1:0] c_rad_ff;
   logic                  c_v_ff;

   always_comb begin
      r2_wide   = (2*XW)'(r2_ff);
      rad_wide  = r2_wide - b_d2_ff;
      c_side_in = b_side_ff;
      if (!b_side_ff.on_seg && (b_d2_ff > r2_wide)) begin
         c_side_in.dom_err = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_side_ff <= c_side_in;
         c_rad_ff  <= rad_wide[fce_pkg::RAD_W-1:0];
      end
   end

   // square-root chain
   logic [fce_pkg::RAD_W-1:0]    sq_rad  [SQ];
   logic [fce_pkg::SQ_REM_W-1:0] sq_rem  [SQ];
   logic [RW-1:0]                sq_root [SQ];

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      if (k == 0) begin : g_first
         fce_sqrt_cell u_cell (
            .clock  (clock),
            .en     (adv),
            .rad_i  (c_rad_ff),
            .rem_i  ('0),
            .root_i ('0),
            .rad_o  (sq_rad[k]),
            .rem_o  (sq_rem[k]),
            .root_o (sq_root[k])
         );
      end else begin : g_rest
         fce_sqrt_cell u_cell (
            .clock  (clock),
            .en     (adv),
            .rad_i  (sq_rad[k-1]),
            .rem_i  (sq_rem[k-1]),
            .root_i (sq_root[k-1]),
            .rad_o  (sq_rad[k]),
            .rem_o  (sq_rem[k]),
            .root_o (sq_root[k])
         );
      end
   end

   // slope divider chain, one quotient bit per cell
   logic [XW-1:0] dv_rem [DS];
   logic [DS-1:0] dv_q   [DS];

   for (genvar j = 0; j < DS; j++) begin : g_div
      if (j == 0) begin : g_first
         fce_div_cell u_cell (
            .clock (clock),
            .en    (adv),
            .dw    (dw_ff),
            .nbit  (num_ff[DS-1]),
            .rem_i ('0),
            .q_i   ('0),
            .rem_o (dv_rem[j]),
            .q_o   (dv_q[j])
         );
      end else begin : g_rest
         fce_div_cell u_cell (
            .clock (clock),
            .en    (adv),
            .dw    (dw_ff),
            .nbit  (num_ff[DS-1-j]),
            .rem_i (dv_rem[j-1]),
            .q_i   (dv_q[j-1]),
            .rem_o (dv_rem[j]),
            .q_o   (dv_q[j])
         );
      end
   end

   // item side data travels alongside the divider cells; the root joins it
   // once the square-root chain is done
   fce_pkg::fce_side_type side_ff [DS];
   fce_pkg::fce_side_type side_in [DS];
   logic                  sv_ff   [DS];
   logic                  sv_in   [DS];

   for (genvar j = 0; j < DS; j++) begin : g_side
      if (j == 0) begin : g_first
         assign side_in[j] = c_side_ff;
         assign sv_in[j]   = c_v_ff;
      end else if (j == SQ) begin : g_merge
         always_comb begin
            side_in[j]      = side_ff[j-1];
            side_in[j].root = sq_root[SQ-1];
         end
         assign sv_in[j] = sv_ff[j-1];
      end else begin : g_pass
         assign side_in[j] = side_ff[j-1];
         assign sv_in[j]   = sv_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (adv) begin
            sv_ff[j] <= sv_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[j] <= side_in[j];
         end
      end
   end

   // m1: low partial product of offset times slope magnitude
   fce_pkg::fce_side_type m1_side_ff;
   logic [fce_pkg::QH-1:0]      m1_qhi_ff;
   logic [XW+fce_pkg::QL-1:0]   m1_plo_ff;
   logic                        m1_v_ff;

   // m2: high partial product
   fce_pkg::fce_side_type m2_side_ff;
   logic [XW+fce_pkg::QH-1:0]   m2_phi_ff;
   logic [XW+fce_pkg::QL-1:0]   m2_plo_ff;
   logic                        m2_v_ff;

   // m3: combined product, scaled down by the fraction bits
   fce_pkg::fce_side_type m3_side_ff;
   logic [fce_pkg::PW-1:0]      prod_full;
   logic [fce_pkg::MAG_W-1:0]   m3_mag_ff;
   logic                        m3_v_ff;

   assign prod_full = {m2_phi_ff, {fce_pkg::QL{1'b0}}} + fce_pkg::PW'(m2_plo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff <= sv_ff[DS-1];
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_side_ff <= side_ff[DS-1];
         m1_qhi_ff  <= dv_q[DS-1][DS-1:fce_pkg::QL];
         m1_plo_ff  <= (XW+fce_pkg::QL)'(side_ff[DS-1].dx)
                       * (XW+fce_pkg::QL)'(dv_q[DS-1][fce_pkg::QL-1:0]);
         m2_side_ff <= m1_side_ff;
         m2_phi_ff  <= (XW+fce_pkg::QH)'(m1_side_ff.dx) * (XW+fce_pkg::QH)'(m1_qhi_ff);
         m2_plo_ff  <= m1_plo_ff;
         m3_side_ff <= m2_side_ff;
         m3_mag_ff  <= prod_full[fce_pkg::PW-1:FB];
      end
   end

   // output stage: add the base y, saturate, select segment or arc, or zero on a domain error
   logic signed [fce_pkg::SUM_W-1:0] mag_s;
   logic signed [fce_pkg::SUM_W-1:0] seg_sum;
   logic signed [fce_pkg::SUM_W-1:0] arc_sum;
   logic signed [XW-1:0]             y_in;
   logic signed [XW-1:0]             y_ff;
   logic                             on_seg_ff;
   logic                             dom_err_ff;

   always_comb begin
      mag_s   = signed'(fce_pkg::SUM_W'(m3_mag_ff));
      seg_sum = fce_pkg::SUM_W'(seg_y0_ff) + (dy_neg_ff ? -mag_s : mag_s);
      arc_sum = fce_pkg::SUM_W'(center_y_ff)
                - signed'(fce_pkg::SUM_W'(m3_side_ff.root));
      if (m3_side_ff.dom_err) begin
         y_in = '0;
      end else if (m3_side_ff.on_seg) begin
         y_in = fce_pkg::sat_y(seg_sum);
      end else begin
         y_in = fce_pkg::sat_y(arc_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= m3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff       <= y_in;
         on_seg_ff  <= m3_side_ff.on_seg;
         dom_err_ff <= m3_side_ff.dom_err;
      end
   end

   assign rsp_ch.valid        = rsp_v_ff;
   assign rsp_ch.y_coord      = y_ff;
   assign rsp_ch.on_segment   = on_seg_ff;
   assign rsp_ch.domain_error = dom_err_ff;

endmodule

`default_nettype wire

// ===== hdl/fce_checker.sv =====
// fce_checker: port-level assertions for fillet_curve_evaluator_core
// bound to the top level below; depends on fce_pkg
`default_nettype none

module fce_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [fce_pkg::XW-1:0]  y_coord,
   input wire logic                    domain_error
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(y_coord))
      else $error("rsp changed while stalled");

   // errored items report zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && domain_error |-> y_coord == '0)
      else $error("domain error with nonzero y");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // the input side only waits on a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req not ready without rsp stall");

endmodule

bind fillet_curve_evaluator_core fce_checker u_fce_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .y_coord      (rsp_ch.y_coord),
   .domain_error (rsp_ch.domain_error)
);

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for fillet_curve_evaluator_core, curve y per x item
// depends on fce_pkg, fce_if and the core; predicts results with its own model
`default_nettype none

class curve_scoreboard;
   int   n_errors;
   logic signed [31:0] want_y[$];
   logic want_seg[$];
   logic want_err[$];
   logic signed [31:0] x_lo, y_lo, x_hi, y_hi, cx, cy;
   logic [30:0] rad;

   function new();
      n_errors = 0;
      x_lo = 0; y_lo = 0; x_hi = 0; y_hi = 0; cx = 0; cy = 0; rad = 0;
   endfunction

   function void set_reg(fce_pkg::csr_idx_type idx, logic [31:0] v);
      case (idx)
         fce_pkg::CSR_SEG_X0:   x_lo = v;
         fce_pkg::CSR_SEG_Y0:   y_lo = v;
         fce_pkg::CSR_SEG_X1:   x_hi = v;
         fce_pkg::CSR_SEG_Y1:   y_hi = v;
         fce_pkg::CSR_CENTER_X: cx = v;
         fce_pkg::CSR_CENTER_Y: cy = v;
         fce_pkg::CSR_RADIUS:   rad = v[30:0];
         default: ;
      endcase
   endfunction

   static function logic signed [31:0] clamp(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   static function logic [63:0] floor_root(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // note an accepted item and queue its expected result
   function void note_item(logic signed [31:0] x);
      logic signed [127:0] dw, slope, yw, d;
      logic [127:0] d2, r2;
      if (x >= x_lo && x <= x_hi) begin
         dw = 128'(x_hi) - 128'(x_lo);
         want_seg.push_back(1'b1);
         if (dw == 0) begin
            want_y.push_back(0); want_err.push_back(1'b1);
         end else begin
            slope = ((128'(y_hi) - 128'(y_lo)) * 128'sd65536) / dw;
            yw = 128'(y_lo) + ((128'(x) - 128'(x_lo)) * slope) / 128'sd65536;
            want_y.push_back(clamp(yw)); want_err.push_back(1'b0);
         end
      end else begin
         d = 128'(x) - 128'(cx);
         if (d < 0) d = -d;
         d2 = d * d;
         r2 = 128'(rad) * 128'(rad);
         want_seg.push_back(1'b0);
         if (d2 > r2) begin
            want_y.push_back(0); want_err.push_back(1'b1);
         end else begin
            yw = 128'(cy) - 128'(floor_root(64'(r2 - d2)));
            want_y.push_back(clamp(yw)); want_err.push_back(1'b0);
         end
      end
   endfunction

   function void check_result(logic signed [31:0] y, logic seg, logic err);
      logic signed [31:0] ey;
      logic es, ee;
      if (want_y.size() == 0) begin
         report("result with nothing pending", 0, y);
         return;
      end
      ey = want_y.pop_front(); es = want_seg.pop_front(); ee = want_err.pop_front();
      if (y !== ey) report("y_coord", ey, y);
      if (seg !== es) report("on_segment", es, seg);
      if (err !== ee) report("domain_error", ee, err);
   endfunction

   function void report(string what, logic [31:0] e, logic [31:0] g);
      $display("mismatch %s: expected %h got %h at %0t", what, e, g, $time);
      n_errors++;
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [fce_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fce_pkg::XW-1:0] csr_wdata = '0;

   fce_req_if req_ch();
   fce_rsp_if rsp_ch();

   fillet_curve_evaluator_core i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   curve_scoreboard curve_sb = new();
   int send_idle_pct = 0;   // sender idle chance, percent
   int recv_idle_pct = 0;   // receiver stall chance, percent
   int hold_off = 0;        // long receiver stall, in cycles
   longint cycle_count = 0;

   initial begin
      req_ch.valid = 0;
      req_ch.x_coord = '0;
      rsp_ch.ready = 0;
   end

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         curve_sb.check_result(rsp_ch.y_coord, rsp_ch.on_segment, rsp_ch.domain_error);
   end

   // register write while the block is idle
   task automatic write_reg(fce_pkg::csr_idx_type idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      curve_sb.set_reg(idx, v);
   endtask

   task automatic write_all(logic [31:0] x0, y0, x1, y1, cxv, cyv, r);
      write_reg(fce_pkg::CSR_SEG_X0, x0);
      write_reg(fce_pkg::CSR_SEG_Y0, y0);
      write_reg(fce_pkg::CSR_SEG_X1, x1);
      write_reg(fce_pkg::CSR_SEG_Y1, y1);
      write_reg(fce_pkg::CSR_CENTER_X, cxv);
      write_reg(fce_pkg::CSR_CENTER_Y, cyv);
      write_reg(fce_pkg::CSR_RADIUS, r);
   endtask

   // offer one item; valid stays high between back-to-back items
   task automatic send_item(logic [31:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.x_coord <= x;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      curve_sb.note_item(x);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (curve_sb.want_y.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // x near the segment ends and the arc, otherwise anywhere
   function automatic logic [31:0] pick_x();
      logic [31:0] base;
      case ($urandom_range(5))
         0: base = curve_sb.x_lo;
         1: base = curve_sb.x_hi;
         2: base = curve_sb.cx;
         3: base = curve_sb.cx + {curve_sb.rad[30], curve_sb.rad};
         default: return $urandom;
      endcase
      return base + 32'($signed($urandom_range(512)) - 256) * (32'd1 << $urandom_range(16));
   endfunction

   task automatic random_setting();
      logic [31:0] a, b;
      a = $urandom; b = $urandom;
      if ($urandom_range(3) == 0) a = a >>> $urandom_range(20);
      b = a + ($urandom >> $urandom_range(31));
      write_all(a, $urandom >>> $urandom_range(30), ($urandom_range(7) == 0) ? a - 1 : b,
                $urandom >>> $urandom_range(30), $urandom >>> $urandom_range(28),
                $urandom, $urandom >> $urandom_range(1, 28));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero width segment at reset settings, then extremes
      send_item(32'h0);
      send_item(32'h1);
      send_item(32'hffffffff);
      drain();
      write_all(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h0, 32'h7fffffff, 32'h7fffffff);
      send_item(32'h80000000);
      send_item(32'h7fffffff);
      send_item(32'h0);
      send_item(32'h00010000);
      drain();
      // steep segment saturates, reversed segment goes to the arc
      write_all(32'h0, 32'h80000000, 32'h1, 32'h7fffffff,
                32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_item(32'h0);
      send_item(32'h1);
      send_item(32'h2);
      send_item(32'h80000000);
      send_item(32'h7fffffff);
      drain();
      write_all(32'h00050000, 32'h0, 32'h00040000, 32'h0,
                32'h0, 32'h00020000, 32'h00010000);
      send_item(32'h00010000);
      send_item(32'hffff0000);
      send_item(32'h00010001);
      send_item(32'h0);
      send_item(32'h00045000);
      drain();

      // long receiver hold-off while items keep coming
      hold_off = 300;
      repeat (150) send_item(pick_x());
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 72 : 0;
         recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 25 : 0;
         for (int s = 0; s < 8; s++) begin
            random_setting();
            repeat (60) send_item(pick_x());
            drain();
         end
      end

      if (curve_sb.n_errors == 0 && curve_sb.want_y.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== fillet_curve_evaluator_core.f =====
hdl/fce_pkg.sv
hdl/fce_if.sv
hdl/fce_div_cell.sv
hdl/fce_sqrt_cell.sv
hdl/fillet_curve_evaluator_core.sv
hdl/fce_checker.sv
bench/tb.sv
